// File: rtl/swrr_pkg.sv
// swrr_pkg: shared types and constants for the selective-repeat receive window
// word structs, opcodes, result kinds, register map and reset values
// no dependencies
`default_nettype none

package swrr_pkg;

  localparam int DEFAULT_WINDOW_DEPTH = 16;
  localparam int SIZE_W = 5;
  localparam int SEQ_W = 32;
  localparam int HANDLE_W = 32;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // opcodes
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_SLIDE = 1'b1;

  // packet kind that marks end of transfer
  localparam logic [1:0] PK_END = 2'd2;

  // result kinds
  localparam logic [2:0] RK_STORED = 3'd0;
  localparam logic [2:0] RK_OUTSIDE = 3'd1;
  localparam logic [2:0] RK_END = 3'd2;
  localparam logic [2:0] RK_DELIVERED = 3'd3;
  localparam logic [2:0] RK_NOTHING = 3'd4;

  // register select (word address bit)
  localparam logic REG_SLOT_SPAN = 1'b0;
  localparam logic REG_INITIAL_START = 1'b1;

  localparam logic [SIZE_W-1:0] SLOT_SPAN_RESET = 5'd10;
  localparam logic [SEQ_W-1:0] INITIAL_START_RESET = 32'd0;
  localparam logic [SEQ_W-1:0] SEQ_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                opcode;
    logic [1:0]          packet_kind;
    logic [SEQ_W-1:0]    seq_num;
    logic [HANDLE_W-1:0] payload_handle;
  } item_t;

  typedef struct packed {
    logic [2:0]          result_kind;
    logic [SEQ_W-1:0]    out_seq;
    logic [HANDLE_W-1:0] out_handle;
    logic                ack_valid;
    logic [SEQ_W-1:0]    ack_seq;
    logic                last;
  } result_t;

  // configuration seen by the window engine
  typedef struct packed {
    logic [SIZE_W-1:0] slot_span;
    logic              restart;
    logic [SEQ_W-1:0]  restart_start;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/swrr_handle_mem.sv
// swrr_handle_mem: payload handle store, one write and one read port
// synchronous (registered) read; no reset on contents
// depends on swrr_pkg
`default_nettype none

module swrr_handle_mem #(
  parameter int WINDOW_DEPTH = swrr_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [$clog2(WINDOW_DEPTH)-1:0]     waddr,
  input  wire logic [swrr_pkg::HANDLE_W-1:0]       wdata,
  input  wire logic                                re,
  input  wire logic [$clog2(WINDOW_DEPTH)-1:0]     raddr,
  output logic      [swrr_pkg::HANDLE_W-1:0]       rdata
);

  logic [swrr_pkg::HANDLE_W-1:0] mem [WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/swrr_apb_regs.sv
// swrr_apb_regs: apb register file for window size and initial start
// flags a window restart when initial start is written
// depends on swrr_pkg
`default_nettype none

module swrr_apb_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [swrr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [swrr_pkg::PDATA_W-1:0]   pwdata,
  output logic      [swrr_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready,
  output swrr_pkg::cfg_t                      cfg
);

  logic [swrr_pkg::SIZE_W-1:0] slot_span;
  logic [swrr_pkg::SEQ_W-1:0]  initial_start;
  logic                        wr_en;
  logic                        reg_sel;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  // registers sit on 4-byte words; low address bits are ignored
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_span <= swrr_pkg::SLOT_SPAN_RESET;
      initial_start <= swrr_pkg::INITIAL_START_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        swrr_pkg::REG_SLOT_SPAN: slot_span <= pwdata[swrr_pkg::SIZE_W-1:0];
        swrr_pkg::REG_INITIAL_START: initial_start <= pwdata[swrr_pkg::SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      swrr_pkg::REG_SLOT_SPAN:
        prdata = {{(swrr_pkg::PDATA_W-swrr_pkg::SIZE_W){1'b0}}, slot_span};
      swrr_pkg::REG_INITIAL_START: prdata = initial_start;
      default: prdata = '0;
    endcase
  end

  assign cfg.slot_span = slot_span;
  assign cfg.restart = wr_en && (reg_sel == swrr_pkg::REG_INITIAL_START);
  assign cfg.restart_start = pwdata[swrr_pkg::SEQ_W-1:0];

endmodule

`default_nettype wire

// File: rtl/sliding_window_receive_reorder_top.sv
// sliding_window_receive_reorder_top: receive side of a selective-repeat window
// window engine plus instances of the register file and the handle memory
// depends on swrr_pkg, swrr_apb_regs, swrr_handle_mem
`default_nettype none

// A word is taken when start is high and busy is low. A packet word is
// handled in its accept cycle and its single result shows on result in the
// next cycle for exactly one cycle with result_valid high; busy stays low,
// so packets may arrive every cycle while no slide holds busy. A slide
// word that finds the head slot empty gives one "nothing" result the next
// cycle, also without busy. A slide that delivers n packets holds busy
// until the walk ends and puts out one delivered result per cycle, the
// n-th with last set. The walk overlaps reads of the handle memory: each
// cycle reads the next head slot while the previous read is being
// reported. The receiver cannot stall, so results are never held back.
// Filled flags are flip-flops that reset and an initial start write clear
// at once; there is no clearing pass.
module sliding_window_receive_reorder_top #(
  parameter int WINDOW_DEPTH = swrr_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // command channel
  input  wire logic                           start,
  input  wire swrr_pkg::item_t                item,
  output logic                                busy,
  output logic                                result_valid,
  output swrr_pkg::result_t                   result,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [swrr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [swrr_pkg::PDATA_W-1:0]   pwdata,
  output logic      [swrr_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  // head + offset, offset below the 5-bit window size
  localparam int SUM_W = ((IDX_W > swrr_pkg::SIZE_W) ? IDX_W : swrr_pkg::SIZE_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  swrr_pkg::cfg_t cfg;

  state_t                        state, state_next;
  logic [WINDOW_DEPTH-1:0]       filled;
  logic [swrr_pkg::SEQ_W-1:0]    window_start;
  logic [IDX_W-1:0]              head_slot;
  logic [swrr_pkg::SEQ_W-1:0]    pend_seq;   // sequence of the read in flight
  logic                          stop;       // walk reached top of sequence space

  logic                          accept;
  logic                          acc_packet;
  logic                          acc_slide;
  logic [swrr_pkg::SEQ_W-1:0]    diff;
  logic                          in_window;
  logic [SUM_W-1:0]              idx_sum;
  logic [IDX_W-1:0]              store_idx;
  logic                          head_filled;
  logic                          take_head;   // deliver the head slot this cycle
  logic [IDX_W-1:0]              head_inc;
  logic                          mem_we;
  logic [swrr_pkg::HANDLE_W-1:0] mem_rdata;

  swrr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swrr_handle_mem #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (store_idx),
    .wdata (item.payload_handle),
    .re    (take_head),
    .raddr (head_slot),
    .rdata (mem_rdata)
  );

  assign busy = (state == ST_DRAIN);
  assign accept = start && !busy;
  assign acc_packet = accept && (item.opcode == swrr_pkg::OP_PACKET);
  assign acc_slide = accept && (item.opcode == swrr_pkg::OP_SLIDE);

  // window check: start <= seq < start + min(size, depth), no wrap
  assign diff = item.seq_num - window_start;
  assign in_window = (item.seq_num >= window_start)
                  && (diff < {{(swrr_pkg::SEQ_W-swrr_pkg::SIZE_W){1'b0}}, cfg.slot_span})
                  && (diff < swrr_pkg::SEQ_W'(WINDOW_DEPTH));

  // ring slot for the offset; for an in-window offset the sum stays below twice the depth
  always_comb begin
    idx_sum = SUM_W'(head_slot) + SUM_W'(diff[swrr_pkg::SIZE_W-1:0]);
    if (idx_sum >= SUM_W'(WINDOW_DEPTH)) begin
      idx_sum = idx_sum - SUM_W'(WINDOW_DEPTH);
    end
    store_idx = idx_sum[IDX_W-1:0];
  end

  assign mem_we = acc_packet && (item.packet_kind != swrr_pkg::PK_END) && in_window;

  assign head_filled = filled[head_slot];
  assign head_inc = (head_slot == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_slot + 1'b1;

  // deliver head on a slide start; walk on while slots stay filled and stop is low
  always_comb begin
    take_head = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc_slide && head_filled) begin
          take_head = 1'b1;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (head_filled && !stop) begin
          take_head = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      filled <= '0;
      window_start <= swrr_pkg::INITIAL_START_RESET;
      head_slot <= '0;
      stop <= 1'b0;
      result_valid <= 1'b0;
    end else if (cfg.restart) begin
      filled <= '0;
      window_start <= cfg.restart_start;
      head_slot <= '0;
      stop <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a slide that starts a walk reports from the drain cycles only
      result_valid <= (accept && !take_head) || (state == ST_DRAIN);
      if (mem_we) begin
        filled[store_idx] <= 1'b1;
      end
      if (take_head) begin
        filled[head_slot] <= 1'b0;
        // at the top of sequence space the window holds still
        if (window_start == swrr_pkg::SEQ_MAX) begin
          stop <= 1'b1;
        end else begin
          window_start <= window_start + 1'b1;
          head_slot <= head_inc;
        end
      end else if (state == ST_DRAIN) begin
        stop <= 1'b0;
      end
    end
  end

  // payload: sequence of the read in flight and the result register
  always_ff @(posedge clk) begin
    if (take_head) begin
      pend_seq <= window_start;
    end
    if (state == ST_DRAIN) begin
      result.result_kind <= swrr_pkg::RK_DELIVERED;
      result.out_seq <= pend_seq;
      result.out_handle <= mem_rdata;
      result.ack_valid <= 1'b1;
      result.ack_seq <= pend_seq;
      result.last <= !take_head;
    end else if (acc_slide && !head_filled) begin
      // empty head: nothing to deliver
      result.result_kind <= swrr_pkg::RK_NOTHING;
      result.out_seq <= '0;
      result.out_handle <= '0;
      result.ack_valid <= 1'b0;
      result.ack_seq <= '0;
      result.last <= 1'b1;
    end else if (acc_packet) begin
      if (item.packet_kind == swrr_pkg::PK_END) begin
        result.result_kind <= swrr_pkg::RK_END;
      end else if (in_window) begin
        result.result_kind <= swrr_pkg::RK_STORED;
      end else begin
        result.result_kind <= swrr_pkg::RK_OUTSIDE;
      end
      result.out_seq <= item.seq_num;
      result.out_handle <= '0;
      result.ack_valid <= 1'b0;
      result.ack_seq <= '0;
      result.last <= 1'b1;
    end
  end

endmodule

`default_nettype wire
